// ===== src/wpsg_pkg.sv =====
// Package for the wavetable/PCM sound generator.
// Holds shared types and constants; no dependencies.
`default_nettype none
package wpsg_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  localparam int unsigned VOL_UNIT = (2 * 32 * 256) / 30;

  // Configuration register indexes.
  localparam logic [1:0] REG_XOR  = 2'd0;
  localparam logic [1:0] REG_PCM  = 2'd1;
  localparam logic [1:0] REG_WAVE = 2'd2;
  localparam logic [1:0] REG_ENV  = 2'd3;

  // One classified command passed from front to back.
  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] off;
    logic [7:0]  data;
    logic [19:0] rom_addr;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/wavetable_pcm_sound_generator.sv =====
// Top level of the sixteen-voice wavetable/PCM sound generator.
// Item stream in on s_axis, results out on m_axis, APB configuration.
// After reset a clearing pass zeroes all 8192 bytes of the register RAM; no
// item reaches the back end meanwhile, configuration writes are taken.
// An accepted item lands in a two-entry queue and is offered to the back
// end from there. The back end writes a byte through S_WRD and S_WRX,
// loads a ROM byte as it takes the item, and answers a read from S_RDW.
// A sample tick walks the voices one at a time through a single-port
// register RAM: each voice passes S_VST, S_VCHK and S_VR1 to S_VR5, where
// a skipped voice ends; a PCM voice then passes S_VMIX and a waveform
// voice S_VWAV and S_VMIX.
// Items are taken while the back end works until the queue is full.
// A result waits in the output register until taken; a stalled receiver
// stops the back end, and the full queue then stops the input.
// s_axis_tdata: func[1:0], reg_offset[14:2], write_data[22:15],
// rom_address[42:23], zero filled to 48 bits.
// m_axis_tuser: kind. m_axis_tdata: read_data[7:0], left[23:8], right[39:24].
// Depends on wpsg_pkg, wpsg_front, wpsg_back.
`default_nettype none
module wavetable_pcm_sound_generator
  import wpsg_pkg::*;
#(
  parameter int unsigned VOICES        = 16,
  parameter int unsigned ROM_ADDR_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // func, reg_offset, write_data, rom_address
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // read_data, left_sample, right_sample
  output logic             m_axis_tuser,   // kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [12:0] xor_q;
  logic [31:0] pcm_q, wave_q, env_q;
  logic        cmd_valid, cmd_ready, busy;
  cmd_t        cmd;
  logic        fr_ready;
  logic [7:0]  rdat;
  logic [15:0] lo, ro;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= '0; pcm_q <= '0; wave_q <= '0; env_q <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_XOR:  xor_q <= pwdata[12:0];
        REG_PCM:  pcm_q <= pwdata;
        REG_WAVE: wave_q <= pwdata;
        REG_ENV:  env_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_XOR:  prdata = {19'd0, xor_q};
      REG_PCM:  prdata = pcm_q;
      REG_WAVE: prdata = wave_q;
      REG_ENV:  prdata = env_q;
      default:  prdata = '0;
    endcase
  end

  wpsg_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(fr_ready),
    .func_i(s_axis_tdata[1:0]), .reg_offset_i(s_axis_tdata[14:2]),
    .write_data_i(s_axis_tdata[22:15]), .rom_address_i(s_axis_tdata[42:23]),
    .address_xor_i(xor_q),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  assign s_axis_tready = fr_ready;

  wpsg_back #(.VOICES(VOICES), .ROM_ADDR_BITS(ROM_ADDR_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .pcm_scale_i(pcm_q), .wave_scale_i(wave_q), .env_scale_i(env_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .read_data_o(rdat), .left_o(lo), .right_o(ro),
    .busy_o(busy)
  );

  assign m_axis_tdata = {ro, lo, rdat};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> !busy)
    else $error("back end takes a command while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("stalled result kind changed");

endmodule
`default_nettype wire

// ===== src/wpsg_front.sv =====
// Front end: accepts items, applies the address XOR and queues commands.
// Depends on wpsg_pkg.
`default_nettype none
module wpsg_front
  import wpsg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [12:0] reg_offset_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [19:0] rom_address_i,
  input  wire logic [12:0] address_xor_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  // Two-entry queue.
  cmd_t       q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= '{func: func_i, off: reg_offset_i ^ address_xor_i,
                     data: write_data_i, rom_addr: rom_address_i};
    end
  end

endmodule
`default_nettype wire

// ===== src/wpsg_back.sv =====
// Back end: register RAM, ROM, per-voice offsets and the voice sequencer.
// Depends on wpsg_pkg.
`default_nettype none
module wpsg_back
  import wpsg_pkg::*;
#(
  parameter int unsigned VOICES        = 16,
  parameter int unsigned ROM_ADDR_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  input  wire logic [31:0] pcm_scale_i,
  input  wire logic [31:0] wave_scale_i,
  input  wire logic [31:0] env_scale_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       read_data_o,
  output logic [15:0]      left_o,
  output logic [15:0]      right_o,
  output logic             busy_o
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_WRD   = 14'b00000000000100,
    S_WRX   = 14'b00000000001000,
    S_RDW   = 14'b00000000010000,
    S_VST   = 14'b00000000100000,
    S_VCHK  = 14'b00000001000000,
    S_VR1   = 14'b00000010000000,
    S_VR2   = 14'b00000100000000,
    S_VR3   = 14'b00001000000000,
    S_VR4   = 14'b00010000000000,
    S_VR5   = 14'b00100000000000,
    S_VWAV  = 14'b01000000000000,
    S_VMIX  = 14'b10000000000000
  } state_e;

  localparam int unsigned CW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned RD = 1 << ROM_ADDR_BITS;

  state_e state_q;

  // Register RAM with one port, registered read.
  logic [7:0]  ram [8192];
  logic [12:0] ram_addr;
  logic        ram_we;
  logic [7:0]  ram_wdata, ram_rd_q;
  always_ff @(posedge clk_i) begin
    if (ram_we) ram[ram_addr] <= ram_wdata;
    ram_rd_q <= ram[ram_addr];
  end

  // PCM ROM, loaded by items; no reset.
  logic [7:0] rom [RD];
  logic [ROM_ADDR_BITS-1:0] rom_addr;
  logic [7:0] rom_rd_q;
  logic       rom_we;
  always_ff @(posedge clk_i) begin
    if (rom_we) rom[rom_addr] <= cmd_i.data;
    rom_rd_q <= rom[rom_addr];
  end

  // Per-voice offsets in flip-flops.
  logic [31:0] soff_q [VOICES];
  logic [31:0] eoff_q [VOICES];

  cmd_t        cmd_q;
  logic [12:0] clr_q;
  logic [CW-1:0] ch_q;
  logic [7:0]  st_q, r1_q, r2_q, r3_q, r4_q, vol_q;
  logic [31:0] lacc_q, racc_q;
  logic        ov_q, kind_q;
  logic [7:0]  rdat_q;
  logic [15:0] lo_q, ro_q;
  logic [31:0] mul_q;
  logic [24:0] pos;
  logic [20:0] pend;
  logic [12:0] base;
  logic [4:0]  pfreq;
  logic [31:0] so, eo;
  logic [6:0]  eidx;
  logic        wmode, oneshot, last_ch;
  logic        pcm_end, wave_end, skip;
  logic [31:0] units;
  logic [31:0] scale;
  logic [63:0] prod;
  logic [39:0] eprod;
  logic [7:0]  smp;
  logic signed [8:0]  sdata;
  logic signed [22:0] ml, mr;
  logic [12:0] vu_l, vu_r;
  logic [31:0] lsum, rsum;

  assign base    = {{(10-CW){1'b0}}, ch_q, 3'b000};
  assign wmode   = st_q[1];
  assign oneshot = st_q[2];
  assign last_ch = (32'(ch_q) == VOICES - 1);
  assign so      = soff_q[ch_q];
  assign eo      = eoff_q[ch_q];
  assign eidx    = eo[22:16];
  assign pfreq   = (r2_q[4:0] == 5'd0) ? 5'd4 : r2_q[4:0];
  assign pos     = {5'd0, r4_q, 12'h000} + {1'b0, so[31:8]};
  assign pend    = {(9'h100 - {1'b0, ram_rd_q}), 12'h000};

  // Key-off conditions, valid in S_VR5 where ram_rd_q holds byte 5.
  assign pcm_end  = !wmode && (pos >= {4'd0, pend});
  assign wave_end = wmode && oneshot && (eo[31:23] != 9'd0);
  assign skip     = !st_q[0] || pcm_end || wave_end;

  assign busy_o = (state_q != S_IDLE);
  assign cmd_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign kind_o = kind_q;
  assign read_data_o = rdat_q;
  assign left_o = lo_q;
  assign right_o = ro_q;

  // Mix products: data * vol * 546 / 256, truncated toward zero.
  assign vu_l = 13'(vol_q[7:4]) * 13'(VOL_UNIT);
  assign vu_r = 13'(vol_q[3:0]) * 13'(VOL_UNIT);
  assign sdata = $signed({smp[7], smp});
  always_comb begin
    ml = 23'(sdata * $signed({1'b0, vu_l}));
    mr = 23'(sdata * $signed({1'b0, vu_r}));
  end
  function automatic logic [31:0] div256(input logic signed [22:0] v);
    logic signed [22:0] t;
    t = v + ((v < 0) ? 23'sd255 : 23'sd0);
    return 32'($signed(t >>> 8));
  endfunction

  assign smp  = wmode ? ram_rd_q : rom_rd_q;
  assign lsum = lacc_q + div256(ml);
  assign rsum = racc_q + div256(mr);

  // Offset steps: (units * scale) >> 16, kept to 32 bits.
  always_comb begin
    units = wmode ? {16'd0, r3_q, r2_q} : {27'd0, pfreq};
    scale = wmode ? wave_scale_i : pcm_scale_i;
    prod  = units * scale;
  end
  assign eprod = 40'(r4_q) * 40'(env_scale_i);

  // Address and strobe selection.
  always_comb begin
    ram_addr = cmd_q.off;
    ram_we = 1'b0;
    ram_wdata = cmd_q.data;
    rom_addr = cmd_i.rom_addr[ROM_ADDR_BITS-1:0];
    rom_we = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_addr = clr_q; ram_we = 1'b1; ram_wdata = 8'd0;
      end
      S_IDLE: begin
        ram_addr = cmd_i.off;
        if (cmd_valid_i && !ov_q && cmd_i.func == FUNC_LOAD) rom_we = 1'b1;
      end
      S_WRX: begin
        ram_we = 1'b1;
      end
      S_VST: ram_addr = base;
      S_VCHK: ram_addr = base + 13'd1;
      S_VR1: ram_addr = base + 13'd2;
      S_VR2: ram_addr = base + 13'd3;
      S_VR3: ram_addr = base + 13'd4;
      S_VR4: ram_addr = base + 13'd5;
      S_VR5: begin
        rom_addr = pos[ROM_ADDR_BITS-1:0];
        if (st_q[0] && (pcm_end || wave_end)) begin
          // The voice keys itself off.
          ram_addr = base; ram_we = 1'b1; ram_wdata = st_q & 8'hfe;
        end else begin
          // Envelope byte of a waveform voice.
          ram_addr = {ram_rd_q[5:0], 7'd0} + {6'd0, eidx};
        end
      end
      S_VWAV: ram_addr = 13'h1000 + {r1_q[5:0], 7'd0} + {6'd0, so[14:8]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      ov_q <= 1'b0;
      kind_q <= 1'b0;
      rdat_q <= '0;
      lo_q <= '0;
      ro_q <= '0;
      ch_q <= '0;
      cmd_q <= '0;
      st_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0;
      vol_q <= '0;
      mul_q <= '0;
      lacc_q <= '0;
      racc_q <= '0;
      for (int i = 0; i < VOICES; i++) begin
        soff_q[i] <= '0;
        eoff_q[i] <= '0;
      end
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 13'd1;
          if (clr_q == 13'h1fff) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i && !ov_q) begin
            cmd_q <= cmd_i;
            case (cmd_i.func)
              FUNC_WRITE: state_q <= S_WRD;
              FUNC_READ: state_q <= S_RDW;
              FUNC_TICK: begin
                state_q <= S_VST; ch_q <= '0;
                lacc_q <= '0; racc_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_WRD: state_q <= S_WRX;
        S_WRX: begin
          // Key-on edge clears the channel's offsets.
          if (cmd_q.off[2:0] == 3'd0 && 32'(cmd_q.off[12:3]) < VOICES &&
              !ram_rd_q[0] && cmd_q.data[0]) begin
            soff_q[cmd_q.off[3+CW-1:3]] <= '0;
            eoff_q[cmd_q.off[3+CW-1:3]] <= '0;
          end
          state_q <= S_IDLE;
        end
        S_RDW: begin
          ov_q <= 1'b1; kind_q <= 1'b0; rdat_q <= ram_rd_q;
          lo_q <= '0; ro_q <= '0;
          state_q <= S_IDLE;
        end
        S_VST: state_q <= S_VCHK;
        S_VCHK: begin
          st_q <= ram_rd_q;
          state_q <= S_VR1;
        end
        S_VR1: begin r1_q <= ram_rd_q; state_q <= S_VR2; end
        S_VR2: begin r2_q <= ram_rd_q; state_q <= S_VR3; end
        S_VR3: begin r3_q <= ram_rd_q; state_q <= S_VR4; end
        S_VR4: begin r4_q <= ram_rd_q; state_q <= S_VR5; end
        S_VR5: begin
          // ram_rd_q holds byte 5 here.
          mul_q <= prod[47:16];
          vol_q <= r1_q;
          if (skip) begin
            if (last_ch) begin
              ov_q <= 1'b1; kind_q <= 1'b1; rdat_q <= '0;
              lo_q <= lacc_q[15:0]; ro_q <= racc_q[15:0];
              state_q <= S_IDLE;
            end else begin
              ch_q <= ch_q + CW'(1); state_q <= S_VST;
            end
          end else if (wmode) begin
            state_q <= S_VWAV;
          end else begin
            state_q <= S_VMIX;
          end
        end
        S_VWAV: begin
          // The envelope byte gives the volumes of a waveform voice.
          vol_q <= ram_rd_q;
          state_q <= S_VMIX;
        end
        S_VMIX: begin
          lacc_q <= lsum;
          racc_q <= rsum;
          soff_q[ch_q] <= so + mul_q;
          if (wmode) eoff_q[ch_q] <= eo + {8'd0, eprod[39:16]};
          if (last_ch) begin
            ov_q <= 1'b1; kind_q <= 1'b1; rdat_q <= '0;
            lo_q <= lsum[15:0];
            ro_q <= rsum[15:0];
            state_q <= S_IDLE;
          end else begin
            ch_q <= ch_q + CW'(1); state_q <= S_VST;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == S_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDW |=> out_valid_o && !kind_o)
    else $error("read result missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_VWAV |-> st_q[1])
    else $error("wave fetch for a PCM voice");

endmodule
`default_nettype wire
